>>> hdl/ipv6fmt_pkg.sv
package ipv6fmt_pkg;

    localparam int GROUP_COUNT = 8;
    localparam int GROUP_BITS  = 16;
    localparam int CHAR_BITS   = 7;

    localparam logic [CHAR_BITS-1:0] CHAR_COLON = 7'h3A;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_F     = 7'h66;

    localparam logic [3:0] RUN_END_TAIL = 4'd8;

    typedef struct packed {
        logic [GROUP_COUNT-1:0][GROUP_BITS-1:0] groups;
        logic                                   has_run;
        logic [2:0]                             run_start;
        logic [3:0]                             run_end;
    } entry_t;

    function automatic logic [1:0] lead_digit(input logic [GROUP_BITS-1:0] v);
        logic [1:0] pos;
        if (v[15:12] != 4'd0)
            pos = 2'd3;
        else if (v[11:8] != 4'd0)
            pos = 2'd2;
        else if (v[7:4] != 4'd0)
            pos = 2'd1;
        else
            pos = 2'd0;
        return pos;
    endfunction

    function automatic logic [CHAR_BITS-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_BITS-1:0] c;
        if (nib < 4'd10)
            c = CHAR_ZERO + {3'd0, nib};
        else
            c = CHAR_A + {3'd0, nib} - 7'd10;
        return c;
    endfunction

endpackage

>>> hdl/ipv6fmt_front.sv
module ipv6fmt_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           address_high,
    input  logic [63:0]           address_low,
    output logic                  busy,
    input  logic                  q_full,
    output logic                  push,
    output ipv6fmt_pkg::entry_t   push_entry
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] high_reg;
    logic [63:0] low_reg;
    logic        accept;

    logic [ipv6fmt_pkg::GROUP_COUNT-1:0] zero;
    logic [ipv6fmt_pkg::GROUP_COUNT-1:0] prev_zero;
    logic [ipv6fmt_pkg::GROUP_COUNT-1:0] next_zero;
    logic [2:0] cur_start;
    logic [3:0] run_len;
    logic [4:0] save;
    logic [4:0] best_save;
    logic [2:0] best_start;
    logic [3:0] best_end;
    logic       found;

    assign busy   = valid_reg & q_full;
    assign accept = start & ~busy;
    assign push   = valid_reg & ~q_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            high_reg <= address_high;
            low_reg  <= address_low;
        end
    end

    // classify: pick the zero run with the largest saving, later run on ties
    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            push_entry.groups[g]     = high_reg[(3 - g) * 16 +: 16];
            push_entry.groups[g + 4] = low_reg[(3 - g) * 16 +: 16];
        end
        for (int g = 0; g < ipv6fmt_pkg::GROUP_COUNT; g++)
            zero[g] = (push_entry.groups[g] == 16'd0);
        prev_zero  = {zero[6:0], 1'b0};
        next_zero  = {1'b0, zero[7:1]};
        cur_start  = 3'd0;
        run_len    = 4'd0;
        save       = 5'd0;
        best_save  = 5'd0;
        best_start = 3'd0;
        best_end   = 4'd0;
        found      = 1'b0;
        for (int k = 0; k < ipv6fmt_pkg::GROUP_COUNT; k++)
        begin
            if (zero[k] && !prev_zero[k])
                cur_start = 3'(k);
            if (zero[k] && !next_zero[k])
            begin
                run_len = 4'(k) + 4'd1 - {1'b0, cur_start};
                save    = {run_len, 1'b0} - 5'd1
                          - {4'd0, (cur_start == 3'd0)} - {4'd0, (k == 7)};
                if (run_len >= 4'd2 && save >= best_save)
                begin
                    best_save  = save;
                    best_start = cur_start;
                    best_end   = 4'(k) + 4'd1;
                    found      = 1'b1;
                end
            end
        end
        push_entry.has_run   = found;
        push_entry.run_start = best_start;
        push_entry.run_end   = best_end;
    end

endmodule

>>> hdl/ipv6fmt_queue.sv
module ipv6fmt_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ipv6fmt_pkg::entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output ipv6fmt_pkg::entry_t q_entry
);

    ipv6fmt_pkg::entry_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_entry = mem_reg[rd_ptr_reg];
    assign do_pop  = pop & q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = ~wr_ptr_reg;
        if (do_pop)
            rd_ptr_next = ~rd_ptr_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

endmodule

>>> hdl/ipv6fmt_back.sv
module ipv6fmt_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ipv6fmt_pkg::entry_t q_entry,
    output logic                pop,
    output logic                strobe,
    output logic [6:0]          text_char,
    output logic                last
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIGIT = 5'b00010,
        ST_COLON = 5'b00100,
        ST_DC1   = 5'b01000,
        ST_DC2   = 5'b10000
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    ipv6fmt_pkg::entry_t entry_reg;
    ipv6fmt_pkg::entry_t entry_next;
    logic [2:0]          grp_reg;
    logic [2:0]          grp_next;
    logic [1:0]          dig_reg;
    logic [1:0]          dig_next;
    logic [6:0]          text_char_reg;
    logic [6:0]          text_char_next;
    logic                last_reg;
    logic                last_next;
    logic                strobe_reg;
    logic                strobe_next;

    logic [15:0] cur_group;
    logic [3:0]  nib;
    logic        finish;

    assign cur_group = entry_reg.groups[grp_reg];
    assign nib       = cur_group[{dig_reg, 2'b00} +: 4];

    always_comb
    begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        grp_next       = grp_reg;
        dig_next       = dig_reg;
        text_char_next = ipv6fmt_pkg::CHAR_COLON;
        last_next      = 1'b0;
        strobe_next    = 1'b0;
        finish         = 1'b0;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                finish = 1'b1;
            end
            ST_COLON:
            begin
                strobe_next = 1'b1;
                state_next  = ST_DIGIT;
                dig_next    = ipv6fmt_pkg::lead_digit(cur_group);
            end
            ST_DIGIT:
            begin
                strobe_next    = 1'b1;
                text_char_next = ipv6fmt_pkg::hex_char(nib);
                if (dig_reg != 2'd0)
                    dig_next = dig_reg - 2'd1;
                else if (grp_reg == 3'd7)
                begin
                    last_next = 1'b1;
                    finish    = 1'b1;
                end
                else
                begin
                    grp_next = grp_reg + 3'd1;
                    if (entry_reg.has_run && (grp_reg + 3'd1 == entry_reg.run_start))
                        state_next = ST_DC1;
                    else
                        state_next = ST_COLON;
                end
            end
            ST_DC1:
            begin
                strobe_next = 1'b1;
                state_next  = ST_DC2;
            end
            ST_DC2:
            begin
                strobe_next = 1'b1;
                if (entry_reg.run_end == ipv6fmt_pkg::RUN_END_TAIL)
                begin
                    last_next = 1'b1;
                    finish    = 1'b1;
                end
                else
                begin
                    grp_next   = entry_reg.run_end[2:0];
                    state_next = ST_DIGIT;
                    dig_next   = ipv6fmt_pkg::lead_digit(
                                     entry_reg.groups[entry_reg.run_end[2:0]]);
                end
            end
            default:
            begin
                finish = 1'b1;
            end
        endcase

        if (finish)
        begin
            if (q_valid)
            begin
                pop        = 1'b1;
                entry_next = q_entry;
                grp_next   = 3'd0;
                if (q_entry.has_run && q_entry.run_start == 3'd0)
                    state_next = ST_DC1;
                else
                begin
                    state_next = ST_DIGIT;
                    dig_next   = ipv6fmt_pkg::lead_digit(q_entry.groups[0]);
                end
            end
            else
                state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        grp_reg       <= grp_next;
        dig_reg       <= dig_next;
        text_char_reg <= text_char_next;
        last_reg      <= last_next;
    end

    assign strobe    = strobe_reg;
    assign text_char = text_char_reg;
    assign last      = last_reg & strobe_reg;

    a_dc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DC1 |=> state_reg == ST_DC2 && strobe_reg)
        else $error("double colon split");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (text_char_reg == ipv6fmt_pkg::CHAR_COLON)
            || (text_char_reg >= ipv6fmt_pkg::CHAR_ZERO
                && text_char_reg <= ipv6fmt_pkg::CHAR_NINE)
            || (text_char_reg >= ipv6fmt_pkg::CHAR_A
                && text_char_reg <= ipv6fmt_pkg::CHAR_F))
        else $error("illegal text character");

    a_pop_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid && (state_reg == ST_IDLE || last_next))
        else $error("entry taken mid transaction");

endmodule

>>> hdl/ipv6_shortest_text_formatter.sv
// Channel   Ports                          Handshake
// -------   -----------------------------  -----------------------------------
// input     address_high, address_low      taken when start high and busy low
// result    text_char, last                one cycle each, flagged by strobe
//
// One character leaves per cycle while text goes out; an address gives 2 to 39
// characters, set by the character sequencer in the back part.
// A taken address passes the front registers, the queue and the back registers.
// A two-entry queue lets the front take new addresses while text goes out.
// busy rises only when the front stage and the queue are both full.
// rst_n clears all control state asynchronously; no clearing pass.
module ipv6_shortest_text_formatter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] address_high,
    input  logic [63:0] address_low,
    output logic        busy,
    output logic        strobe,
    output logic [6:0]  text_char,
    output logic        last
);

    ipv6fmt_pkg::entry_t push_entry;
    ipv6fmt_pkg::entry_t q_entry;
    logic                push;
    logic                q_full;
    logic                q_valid;
    logic                pop;

    ipv6fmt_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .address_high (address_high),
        .address_low  (address_low),
        .busy         (busy),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    ipv6fmt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    ipv6fmt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .strobe    (strobe),
        .text_char (text_char),
        .last      (last)
    );

endmodule

>>> dv/ipv6_shortest_text_formatter_tb.sv
module ipv6_shortest_text_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_MAX    = 39;
    localparam int QUIET_LIMIT = 2000;
    localparam int CALM_TAIL   = 60;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } address_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } glyph_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic [63:0] address_high = '0;
    logic [63:0] address_low  = '0;
    logic        busy;
    logic        strobe;
    logic [6:0]  text_char;
    logic        last;

    address_t address_queue[$];
    glyph_t   expected_text[$];
    address_t upcoming;
    glyph_t   want;

    int errors           = 0;
    int addresses_taken  = 0;
    int chars_seen       = 0;
    int compressed_count = 0;
    int all_zero_count   = 0;
    int idle_left        = 0;
    int quiet_cycles     = 0;

    ipv6_shortest_text_formatter i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .address_high (address_high),
        .address_low  (address_low),
        .busy         (busy),
        .strobe       (strobe),
        .text_char    (text_char),
        .last         (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [6:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return ipv6fmt_pkg::CHAR_ZERO + 7'(nib);
        return ipv6fmt_pkg::CHAR_A + 7'(nib) - 7'd10;
    endfunction

    // Render the groups; groups run_lo..run_hi-1 collapse to "::" when run_lo < run_hi.
    function automatic int render_text(input logic [15:0] grp [ipv6fmt_pkg::GROUP_COUNT],
                                       input int run_lo, input int run_hi,
                                       output logic [6:0] txt [TEXT_MAX]);
        int  len;
        int  k;
        int  d;
        bit  started;
        bit  collapse;
        logic [3:0] nib;
        len = 0;
        k = 0;
        collapse = run_lo < run_hi;
        while (k < ipv6fmt_pkg::GROUP_COUNT)
        begin
            if (collapse && k == run_lo)
            begin
                txt[len] = ipv6fmt_pkg::CHAR_COLON;
                txt[len + 1] = ipv6fmt_pkg::CHAR_COLON;
                len = len + 2;
                k = run_hi;
            end
            else
            begin
                if (k != 0 && !(collapse && k == run_hi))
                begin
                    txt[len] = ipv6fmt_pkg::CHAR_COLON;
                    len++;
                end
                started = 1'b0;
                for (d = 3; d >= 0; d--)
                begin
                    nib = grp[k][d*4 +: 4];
                    if (nib != 4'd0 || started || d == 0)
                    begin
                        txt[len] = nibble_char(nib);
                        len++;
                        started = 1'b1;
                    end
                end
                k++;
            end
        end
        return len;
    endfunction

    task automatic predict_text(input address_t addr);
        logic [15:0] grp [ipv6fmt_pkg::GROUP_COUNT];
        logic [6:0]  best [TEXT_MAX];
        logic [6:0]  cand [TEXT_MAX];
        int          best_len;
        int          cand_len;
        int          i;
        int          j;
        int          k;
        bit          better;
        bit          decided;
        bit          took_run;
        glyph_t      g;
        for (i = 0; i < ipv6fmt_pkg::GROUP_COUNT; i++)
            grp[i] = (i < 4) ? addr.high[(3 - i)*16 +: 16] : addr.low[(7 - i)*16 +: 16];
        best_len = render_text(grp, 0, 0, best);
        took_run = 1'b0;
        i = 0;
        while (i < ipv6fmt_pkg::GROUP_COUNT)
        begin
            if (grp[i] != 16'd0)
                i++;
            else
            begin
                j = i;
                while (j < ipv6fmt_pkg::GROUP_COUNT && grp[j] == 16'd0)
                    j++;
                if (j - i >= 2)
                begin
                    cand_len = render_text(grp, i, j, cand);
                    better = cand_len < best_len;
                    if (cand_len == best_len)
                    begin
                        decided = 1'b0;
                        for (k = 0; k < cand_len; k++)
                        begin
                            if (!decided && cand[k] != best[k])
                            begin
                                better = cand[k] < best[k];
                                decided = 1'b1;
                            end
                        end
                    end
                    if (better)
                    begin
                        best = cand;
                        best_len = cand_len;
                        took_run = 1'b1;
                    end
                end
                i = j;
            end
        end
        if (took_run)
            compressed_count++;
        if (best_len == 2)
            all_zero_count++;
        for (k = 0; k < best_len; k++)
        begin
            g.ch = best[k];
            g.last = (k == best_len - 1);
            expected_text = {expected_text, g};
        end
    endtask

    function automatic logic [15:0] random_group();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'd0;
            4:          return 16'($urandom_range(1, 15));
            5:          return 16'($urandom_range(16, 255));
            6:          return 16'($urandom_range(256, 4095));
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic add_address(input logic [63:0] h, input logic [63:0] l);
        address_t a;
        a.high = h;
        a.low = l;
        address_queue = {address_queue, a};
    endtask

    // Driver: present the next transaction once the current one is taken, with random idle gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            address_high <= '0;
            address_low <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_text({address_high, address_low});
                addresses_taken++;
            end
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (address_queue.size() > 0)
                begin
                    upcoming = address_queue.pop_front();
                    start <= 1'b1;
                    address_high <= upcoming.high;
                    address_low <= upcoming.low;
                    if (address_queue.size() > CALM_TAIL && (addresses_taken / 40) % 3 != 1
                        && $urandom_range(0, 5) == 0)
                        idle_left = $urandom_range(1, 12);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: compare each character against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            chars_seen++;
            if (expected_text.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected character: expected none, actual char %h last %b",
                         $time, text_char, last);
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_char !== want.ch)
                begin
                    errors++;
                    $display("%0t: text_char mismatch: expected %h, actual %h",
                             $time, want.ch, text_char);
                end
                if (last !== want.last)
                begin
                    errors++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout with %0d characters outstanding",
                         $time, expected_text.size());
                $display("ipv6_shortest_text_formatter_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] g [ipv6fmt_pkg::GROUP_COUNT];
        int          n;
        int          i;

        add_address(64'h0, 64'h0);
        add_address('1, '1);
        add_address(64'h0001_0000_0001_0001, 64'h0001_0001_0001_0001);
        add_address(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001);
        add_address(64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000);
        add_address(64'h0001_0002_0000_0000, 64'h0000_0003_0004_0005);
        add_address(64'h0001_0000_0000_0001, 64'h0000_0000_0001_0001);
        add_address(64'h0001_0000_0000_0001, 64'h0000_0000_0000_0001);
        add_address(64'h0001_0000_0000_0000, 64'h0001_0000_0000_0001);
        add_address(64'h0000_0000_0001_0000, 64'h0000_0001_0001_0001);
        add_address(64'h0000_0000_0001_0001, 64'h0001_0001_0000_0000);
        add_address(64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001);
        add_address(64'h0001_0000_0001_0000, 64'h0001_0000_0001_0000);
        add_address(64'h000f_0010_00ff_0100, 64'h0fff_1000_abcd_ffff);
        add_address(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        add_address(64'h0000_0000_0000_0000, 64'h0000_0000_0000_ffff);
        add_address(64'hffff_0000_0000_0000, 64'h0000_0000_0000_0000);
        add_address(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000);
        add_address(64'h0000_0000_0000_0000, 64'h0000_0000_0000_8000);
        add_address(64'h00a0_0b00_c000_000d, 64'h0000_0000_e000_0f00);

        for (n = 0; n < 460; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                add_address({$urandom, $urandom}, {$urandom, $urandom});
            else
            begin
                for (i = 0; i < ipv6fmt_pkg::GROUP_COUNT; i++)
                    g[i] = random_group();
                add_address({g[0], g[1], g[2], g[3]}, {g[4], g[5], g[6], g[7]});
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (address_queue.size() == 0 && !start);
        wait (expected_text.size() == 0);
        repeat (12) @(posedge clk);

        if (expected_text.size() != 0)
        begin
            errors++;
            $display("%0t: %0d characters never arrived", $time, expected_text.size());
        end
        $display("covered %0d addresses and %0d characters", addresses_taken, chars_seen);
        $display("%0d texts shortened with a zero run, %0d all-zero addresses",
                 compressed_count, all_zero_count);
        if (errors == 0)
            $display("ipv6_shortest_text_formatter_tb: clean");
        else
            $display("ipv6_shortest_text_formatter_tb: errors");
        $finish;
    end

endmodule
